// ===== design/fbfl_pkg.sv =====
// Shared types and constants for the fixed-size block free-list allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package fbfl_pkg;

  localparam int MAX_BLOCKS      = 256;
  localparam int MAX_BLOCK_BYTES = 4096;
  localparam int MIN_BLOCK_BYTES = 4;

  localparam int IDX_W    = $clog2(MAX_BLOCKS);
  localparam int LINK_W   = IDX_W + 1;
  localparam int COUNT_W  = 9;
  localparam int SIZE_W   = 13;
  localparam int OFF_W    = 20;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [LINK_W-1:0]  NULL_LINK   = LINK_W'(MAX_BLOCKS);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(64);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_BADCFG = 3'd2,
    ST_NOINIT = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_COUNT = 2'd0,
    REG_BLOCK_SIZE  = 2'd1
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic    head_read;    // read link of current head
    logic    free_push;    // link freed block to head, make it head
    logic    pop;          // head takes link read last cycle
    logic    sweep_start;
    logic    sweep_step;
    logic    init_commit;
    logic    pend_load;
    status_t pend_status;
    logic    pend_grant;   // pending result carries head index and offset
    logic    out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cfg_ok;
    logic list_ready;
    logic head_null;
    logic idx_in_range;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/fbfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fbfl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/fbfl_ctrl.sv =====
// Controller for the block allocator: sequences init sweep, alloc and free.
// Depends on fbfl_pkg; drives fbfl_dp through dp_cmd_t.
`default_nettype none

module fbfl_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [fbfl_pkg::CMD_W-1:0] in_command,
  output logic                           in_stall,
  input  wire fbfl_pkg::dp_sts_t          sts,
  output fbfl_pkg::dp_cmd_t              cmd
);
  import fbfl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_SWEEP
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_valid_r, pend_valid_nxt;
  logic   can_take;
  logic   accept;

  always_comb begin
    cmd       = '0;
    cmd.pend_status = ST_OK;
    state_nxt = state_r;

    // pending result moves to the output stage whenever that stage frees up
    cmd.out_load = pend_valid_r && sts.out_free;
    can_take     = (state_r == S_IDLE) && (!pend_valid_r || sts.out_free);
    in_stall     = !can_take;
    accept       = in_valid && can_take;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (opcode_t'(in_command))
            CMD_INIT: begin
              if (!sts.cfg_ok) begin
                cmd.pend_load   = 1'b1;
                cmd.pend_status = ST_BADCFG;
              end else begin
                cmd.sweep_start = 1'b1;
                state_nxt       = S_SWEEP;
              end
            end
            CMD_ALLOC: begin
              if (!sts.list_ready) begin
                cmd.pend_load   = 1'b1;
                cmd.pend_status = ST_NOINIT;
              end else if (sts.head_null) begin
                cmd.pend_load   = 1'b1;
                cmd.pend_status = ST_EMPTY;
              end else begin
                cmd.head_read = 1'b1;
                state_nxt     = S_ALLOC;
              end
            end
            CMD_FREE: begin
              cmd.pend_load = 1'b1;
              if (!sts.list_ready) begin
                cmd.pend_status = ST_NOINIT;
              end else if (!sts.idx_in_range) begin
                cmd.pend_status = ST_RANGE;
              end else begin
                cmd.free_push   = 1'b1;
              end
            end
            default: begin
              cmd.pend_load = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        cmd.pop        = 1'b1;
        cmd.pend_load  = 1'b1;
        cmd.pend_grant = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.init_commit = 1'b1;
          cmd.pend_load   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    pend_valid_nxt = (pend_valid_r && !cmd.out_load) || cmd.pend_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/fbfl_dp.sv =====
// Datapath for the block allocator: config registers, head, link RAM,
// init sweep counter, pending result and output stage.
// Depends on fbfl_pkg and fbfl_ram.
`default_nettype none

module fbfl_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire fbfl_pkg::dp_cmd_t                cmd,
  output fbfl_pkg::dp_sts_t                    sts,
  input  wire logic                            cfg_we,
  input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [fbfl_pkg::IDX_W-1:0]      in_block_index,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic      [fbfl_pkg::STATUS_W-1:0]   out_status,
  output logic      [fbfl_pkg::IDX_W-1:0]      out_granted_index,
  output logic      [fbfl_pkg::OFF_W-1:0]      out_granted_offset
);
  import fbfl_pkg::*;

  localparam int PROD_W = IDX_W + SIZE_W;

  logic [LINK_W-1:0]  head_r, head_nxt;
  logic               ready_r, ready_nxt;
  logic [COUNT_W-1:0] count_latch_r, count_latch_nxt;
  logic [SIZE_W-1:0]  size_latch_r, size_latch_nxt;
  logic [COUNT_W-1:0] block_count_r, block_count_nxt;
  logic [SIZE_W-1:0]  block_size_r, block_size_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0]   sweep_cnt_r, sweep_cnt_nxt;
  logic [STATUS_W-1:0] pend_status_r;
  logic [IDX_W-1:0]   pend_index_r;
  logic [OFF_W-1:0]   pend_offset_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]   out_index_r;
  logic [OFF_W-1:0]   out_offset_r;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic [LINK_W-1:0]  ram_rdata;
  logic [PROD_W-1:0]  prod;
  logic [COUNT_W-1:0] sweep_next;

  fbfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.head_read),
    .raddr (head_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign sweep_next = {1'b0, sweep_cnt_r} + COUNT_W'(1);
  assign prod       = PROD_W'(head_r[IDX_W-1:0]) * PROD_W'(size_latch_r);

  always_comb begin
    sts.cfg_ok       = (block_count_r != '0) && (block_count_r <= COUNT_W'(MAX_BLOCKS)) &&
                       (block_size_r >= SIZE_W'(MIN_BLOCK_BYTES)) &&
                       (block_size_r <= SIZE_W'(MAX_BLOCK_BYTES));
    sts.list_ready   = ready_r;
    sts.head_null    = (head_r >= NULL_LINK);
    sts.idx_in_range = ({1'b0, in_block_index} < count_latch_r);
    sts.sweep_last   = (sweep_next == block_count_r);
    sts.out_free     = !out_valid_r || !out_stall;
  end

  always_comb begin
    // sweep links each block to the next; last one ends the list
    ram_we    = cmd.free_push || cmd.sweep_step;
    ram_waddr = cmd.sweep_step ? sweep_cnt_r : in_block_index;
    if (cmd.sweep_step) begin
      ram_wdata = sts.sweep_last ? NULL_LINK : LINK_W'(sweep_next);
    end else begin
      ram_wdata = head_r;
    end

    head_nxt        = head_r;
    ready_nxt       = ready_r;
    count_latch_nxt = count_latch_r;
    size_latch_nxt  = size_latch_r;
    if (cmd.free_push) begin
      head_nxt = {1'b0, in_block_index};
    end
    if (cmd.pop) begin
      head_nxt = ram_rdata;
    end
    if (cmd.init_commit) begin
      head_nxt        = '0;
      ready_nxt       = 1'b1;
      count_latch_nxt = block_count_r;
      size_latch_nxt  = block_size_r;
    end

    sweep_cnt_nxt = sweep_cnt_r;
    if (cmd.sweep_start) begin
      sweep_cnt_nxt = '0;
    end else if (cmd.sweep_step) begin
      sweep_cnt_nxt = sweep_cnt_r + IDX_W'(1);
    end

    block_count_nxt = block_count_r;
    block_size_nxt  = block_size_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BLOCK_COUNT: block_count_nxt = cfg_data[COUNT_W-1:0];
        REG_BLOCK_SIZE:  block_size_nxt  = cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end

    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= NULL_LINK;
      ready_r       <= 1'b0;
      count_latch_r <= '0;
      size_latch_r  <= '0;
      block_count_r <= COUNT_RESET;
      block_size_r  <= SIZE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      ready_r       <= ready_nxt;
      count_latch_r <= count_latch_nxt;
      size_latch_r  <= size_latch_nxt;
      block_count_r <= block_count_nxt;
      block_size_r  <= block_size_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sweep_cnt_r <= sweep_cnt_nxt;
    if (cmd.pend_load) begin
      pend_status_r <= cmd.pend_status;
      pend_index_r  <= cmd.pend_grant ? head_r[IDX_W-1:0] : '0;
      pend_offset_r <= cmd.pend_grant ? prod[OFF_W-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= pend_status_r;
      out_index_r  <= pend_index_r;
      out_offset_r <= pend_offset_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_index  = out_index_r;
  assign out_granted_offset = out_offset_r;

endmodule

`default_nettype wire

// ===== design/fixed_block_free_list_allocator_core.sv =====
// Fixed-size block free-list allocator: input item is a command (init,
// alloc, free) with a block index; each item gives one result item with
// status, granted index and byte offset. Config port sets count and size.
//
// Usage:
//   in_*  : item accepted when in_valid is high and in_stall low.
//   out_* : result taken when out_valid is high and out_stall low.
//   cfg_* : register write when cfg_valid and cfg_ready are high; index 0
//           is block count, 1 is block size. Write only while idle.
// Result path: every result passes the pending result register and then
// the output register; a successful alloc first reads the link RAM, and a
// successful init first writes one link RAM entry per block.
// A free, an error or an unknown command leaves the controller idle; a
// successful alloc holds in_stall high for its registered link RAM read,
// an init while it writes one link RAM entry per block.
// A pending result register and the output register hold up to two results
// while out_stall is high; further items wait in in_stall.
// Reset: list not initialized, head null, count 256, size 64. The link RAM
// is not cleared; init writes every entry it later reads.
// Depends on fbfl_pkg, fbfl_ctrl, fbfl_dp, fbfl_ram.
`default_nettype none

module fixed_block_free_list_allocator_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fbfl_pkg::CMD_W-1:0]      in_command,
  input  wire logic [fbfl_pkg::IDX_W-1:0]      in_block_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [fbfl_pkg::STATUS_W-1:0]   out_status,
  output logic      [fbfl_pkg::IDX_W-1:0]      out_granted_index,
  output logic      [fbfl_pkg::OFF_W-1:0]      out_granted_offset,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbfl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  fbfl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  fbfl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_block_index     (in_block_index),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_index  (out_granted_index),
    .out_granted_offset (out_granted_offset)
  );

endmodule

`default_nettype wire

// ===== tb/tb_fixed_block_free_list_allocator_core.sv =====
// Self-checking testbench for fixed_block_free_list_allocator_core: a free-list predictor
// in a small scoreboard class checks every result item against its command item.
// Depends on fbfl_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module tb_fixed_block_free_list_allocator_core;
  import fbfl_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_UNKNOWN  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int TOTAL_ITEMS = 1750;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] index;
    logic [OFF_W-1:0] offset;
  } grant_t;

  class free_list_scoreboard;
    logic [LINK_W-1:0]  link_mem [MAX_BLOCKS];
    logic [LINK_W-1:0]  head_blk;
    logic               list_up;
    logic [COUNT_W-1:0] count_lat;
    logic [SIZE_W-1:0]  size_lat;
    logic [COUNT_W-1:0] reg_count;
    logic [SIZE_W-1:0]  reg_size;
    logic [IDX_W-1:0]   held[$];   // blocks handed out and not yet returned
    grant_t             grants_due[$];
    int                 errors;

    function new();
      head_blk  = NULL_LINK;
      list_up   = 1'b0;
      count_lat = '0;
      size_lat  = '0;
      reg_count = COUNT_RESET;
      reg_size  = SIZE_RESET;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_BLOCK_COUNT) reg_count = data[COUNT_W-1:0];
      else if (idx == REG_BLOCK_SIZE) reg_size = data[SIZE_W-1:0];
    endfunction

    function int outstanding();
      return grants_due.size();
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx);
      grant_t g;
      logic [IDX_W-1:0] blk;
      int i;
      g.status = ST_OK;
      g.index  = '0;
      g.offset = '0;
      case (cmd)
        CMD_INIT: begin
          if (reg_count == 0 || reg_count > MAX_BLOCKS ||
              reg_size < MIN_BLOCK_BYTES || reg_size > MAX_BLOCK_BYTES) begin
            g.status = ST_BADCFG;
          end else begin
            for (i = 0; i < reg_count; i++)
              link_mem[i] = (i + 1 == reg_count) ? NULL_LINK : LINK_W'(i + 1);
            head_blk  = '0;
            count_lat = reg_count;
            size_lat  = reg_size;
            list_up   = 1'b1;
            held.delete();
          end
        end
        CMD_ALLOC: begin
          if (!list_up) g.status = ST_NOINIT;
          else if (head_blk[LINK_W-1]) g.status = ST_EMPTY;
          else begin
            blk      = head_blk[IDX_W-1:0];
            head_blk = link_mem[blk];
            g.index  = blk;
            g.offset = OFF_W'(int'(blk) * int'(size_lat));
            held.push_back(blk);
          end
        end
        CMD_FREE: begin
          if (!list_up) g.status = ST_NOINIT;
          else if (idx >= count_lat) g.status = ST_RANGE;
          else begin
            link_mem[idx] = head_blk;
            head_blk = {1'b0, idx};
            for (i = held.size() - 1; i >= 0; i--)
              if (held[i] == idx) held.delete(i);
          end
        end
        default: ;
      endcase
      grants_due.push_back(g);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] gi,
                               logic [OFF_W-1:0] go);
      grant_t g;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result item status %0d index %0d offset %0d",
                 $time, st, gi, go);
        errors++;
        return;
      end
      g = grants_due.pop_front();
      if (st !== g.status) begin
        $display("%0t: status expected %0d, got %0d", $time, g.status, st);
        errors++;
      end
      if (gi !== g.index) begin
        $display("%0t: granted_index expected %0d, got %0d", $time, g.index, gi);
        errors++;
      end
      if (go !== g.offset) begin
        $display("%0t: granted_offset expected %0d, got %0d", $time, g.offset, go);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command = '0;
  logic [IDX_W-1:0]      in_block_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [IDX_W-1:0]      out_granted_index;
  logic [OFF_W-1:0]      out_granted_offset;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  free_list_scoreboard sb = new();
  int     items_sent = 0;
  int     burst_left = 0;
  bit     gaps_on = 1'b1;
  longint cycles = 0;
  int     stall_mode = 0;
  int     mode_left = 0;
  int     run_left = 0;

  fixed_block_free_list_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_block_index(in_block_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_granted_index(out_granted_index),
    .out_granted_offset(out_granted_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_fixed_block_free_list_allocator_core: done, errors");
      $finish;
    end
  end

  // Receiver: take result items and stall in modes (never, random, long runs).
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_granted_index, out_granted_offset);
    if (mode_left == 0) begin
      stall_mode = $urandom_range(2);
      mode_left = $urandom_range(300, 40);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3) == 0);
      default: begin
        if (run_left == 0) begin
          out_stall <= ~out_stall;
          run_left = $urandom_range(15, 1);
        end else begin
          out_stall <= out_stall;
          run_left--;
        end
      end
    endcase
  end

  // Hold the item until accepted; leaves valid high for a back-to-back item.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx);
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_block_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_command(cmd, idx);
    items_sent++;
  endtask

  task automatic feed(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end
      burst_left = $urandom_range(30, 1);
    end
    burst_left--;
    send_item(cmd, idx);
  endtask

  // Drop valid and wait until every expected result item has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_command();
    int r;
    r = $urandom_range(99);
    if (r < 45) feed(CMD_ALLOC, IDX_W'($urandom_range(255)));
    else if (r < 80 && sb.held.size() > 0)
      feed(CMD_FREE, sb.held[$urandom_range(sb.held.size() - 1)]);
    else if (r < 92) feed(CMD_FREE, IDX_W'($urandom_range(255)));  // range errors, double frees
    else if (r < 96) feed(CMD_INIT, IDX_W'($urandom_range(255)));
    else feed(CMD_UNKNOWN, IDX_W'($urandom_range(255)));
  endtask

  task automatic setup_pool();
    int r;
    logic [CFG_DATA_W-1:0] cnt, sz;
    r = $urandom_range(99);
    if (r < 70) cnt = CFG_DATA_W'($urandom_range(16, 1));
    else if (r < 85) cnt = CFG_DATA_W'($urandom_range(255, 17));
    else if (r < 95) cnt = CFG_DATA_W'(MAX_BLOCKS);
    else if (r < 98) cnt = '0;
    else cnt = CFG_DATA_W'($urandom_range(511, 257));
    if ($urandom_range(9) == 0)
      cnt[CFG_DATA_W-1:COUNT_W] = (CFG_DATA_W-COUNT_W)'($urandom_range(15));
    r = $urandom_range(99);
    if (r < 80) sz = CFG_DATA_W'($urandom_range(MAX_BLOCK_BYTES, MIN_BLOCK_BYTES));
    else if (r < 85) sz = CFG_DATA_W'(MIN_BLOCK_BYTES);
    else if (r < 90) sz = CFG_DATA_W'(MAX_BLOCK_BYTES);
    else sz = CFG_DATA_W'($urandom_range(8191));
    if ($urandom_range(1)) begin
      write_reg(REG_BLOCK_COUNT, cnt);
      write_reg(REG_BLOCK_SIZE, sz);
    end else begin
      write_reg(REG_BLOCK_SIZE, sz);
      write_reg(REG_BLOCK_COUNT, cnt);
    end
    if ($urandom_range(9) == 0)
      write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom_range(8191)));
  endtask

  initial begin
    int len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // use before init, unknown command
    send_item(CMD_ALLOC, 8'h00);
    send_item(CMD_FREE, 8'h00);
    send_item(CMD_FREE, 8'hFF);
    send_item(CMD_UNKNOWN, 8'hAA);
    // bad configurations leave the list down
    drain();
    write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(0));
    send_item(CMD_INIT, 8'h00);
    drain();
    write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(MAX_BLOCKS));
    write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(MIN_BLOCK_BYTES - 1));
    send_item(CMD_INIT, 8'h00);
    drain();
    write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(MAX_BLOCK_BYTES + 1));
    send_item(CMD_INIT, 8'h00);
    drain();
    write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(MAX_BLOCKS + 1));
    write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(64));
    send_item(CMD_INIT, 8'h00);
    send_item(CMD_ALLOC, 8'h00);
    // largest pool, largest blocks, double free
    drain();
    write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(MAX_BLOCKS));
    write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(MAX_BLOCK_BYTES));
    send_item(CMD_INIT, 8'h00);
    send_item(CMD_ALLOC, 8'h00);
    send_item(CMD_ALLOC, 8'h00);
    send_item(CMD_FREE, 8'hFF);
    send_item(CMD_ALLOC, 8'h00);
    send_item(CMD_FREE, 8'h01);
    send_item(CMD_FREE, 8'h01);
    send_item(CMD_ALLOC, 8'h00);
    send_item(CMD_ALLOC, 8'h00);
    // small pool; size change after init must not apply until the next init
    drain();
    write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(3));
    write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(MIN_BLOCK_BYTES));
    send_item(CMD_INIT, 8'h00);
    drain();
    write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(8));
    repeat (4) send_item(CMD_ALLOC, 8'h00);
    send_item(CMD_FREE, 8'h03);
    send_item(CMD_FREE, 8'hFF);
    send_item(CMD_UNKNOWN, 8'h55);

    while (items_sent < TOTAL_ITEMS) begin
      drain();
      setup_pool();
      gaps_on = ($urandom_range(3) != 0);
      burst_left = 0;
      feed(CMD_INIT, IDX_W'($urandom_range(255)));
      len = $urandom_range(80, 20);
      repeat (len) random_command();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_fixed_block_free_list_allocator_core: done, clean");
    end else begin
      $display("tb_fixed_block_free_list_allocator_core: done, errors");
    end
    $finish;
  end

endmodule
